### rtl/mvcc_pkg.sv
// shared types and constants of the version chain table
package mvcc_pkg;

  // command codes of the input beat
  localparam logic [1:0] CMD_READ     = 2'd0;
  localparam logic [1:0] CMD_WRITE    = 2'd1;
  localparam logic [1:0] CMD_FINISH   = 2'd2;
  localparam logic [1:0] CMD_ROLLBACK = 2'd3;

  localparam int unsigned TXN_W   = 32;
  localparam int unsigned TS_W    = 48;
  localparam int unsigned REF_W   = 32;
  localparam int unsigned CNTO_W  = 5;
  localparam int unsigned THR_W   = 5;
  localparam int unsigned ENTRY_W = TXN_W + TS_W + REF_W + 1;
  localparam int unsigned IN_W    = 168;
  localparam int unsigned OUT_W   = 40;

  // one stored version
  typedef struct packed {
    logic               done;
    logic [REF_W-1:0]   vref;
    logic [TS_W-1:0]    ts;
    logic [TXN_W-1:0]   txn;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FIN
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic fin;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

### rtl/mvcc_ram.sv
// generic single write, single read ram with registered read data
module mvcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/mvcc_ctrl.sv
// command sequencer of the version chain table
module mvcc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mvcc_pkg::ctl_sts_t sts_i,
  output mvcc_pkg::ctl_cmd_t cmd_o
);
  import mvcc_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/mvcc_dpath.sv
// entry store, ring pointers, scan and compaction logic, result register
module mvcc_dpath #(
  parameter int unsigned MaxVersions = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mvcc_pkg::ctl_cmd_t           cmd_i,
  output mvcc_pkg::ctl_sts_t           sts_o,
  input  logic [mvcc_pkg::IN_W-1:0]    in_data_i,
  input  logic                         cfg_we_i,
  input  logic [mvcc_pkg::THR_W-1:0]   cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mvcc_pkg::OUT_W-1:0]   out_data_o
);
  import mvcc_pkg::*;

  localparam int unsigned AW = $clog2(MaxVersions);
  localparam int unsigned CW = $clog2(MaxVersions + 1);
  localparam int unsigned XW = CW + THR_W;

  // captured command
  logic [1:0]       op_q;
  logic [TXN_W-1:0] txn_q;
  logic [TS_W-1:0]  ts_q;
  logic [REF_W-1:0] vref_q;
  logic [TS_W-1:0]  min_ts_q;

  logic [THR_W-1:0] thr_q;
  logic [AW-1:0]    head_q;
  logic [CW-1:0]    cnt_q;
  logic [CW-1:0]    rd_idx_q, wr_idx_q, pend_idx_q;
  logic             pend_q, hit_q, full_q, compact_q;
  logic [REF_W-1:0] hit_ref_q;

  logic             out_valid_q;
  logic [REF_W-1:0] out_handle_q;
  logic             out_origin_q, out_status_q;
  logic [CNTO_W-1:0] out_cnt_q;

  // ram ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  logic             issue, match_txn, drop, scan_done;
  logic [XW-1:0]    cnt_inc, cnt_ext;

  mvcc_ram #(
    .Width (ENTRY_W),
    .Depth (2 ** AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // scan issue and compare on returned entry
  assign issue     = cmd_i.scan && (rd_idx_q < cnt_q) && !hit_q;
  assign match_txn = (ram_rdata.txn == txn_q);
  assign drop      = (op_q == CMD_ROLLBACK) ? match_txn : (ram_rdata.ts < min_ts_q);
  assign scan_done = !pend_q && !issue;
  assign cnt_inc   = XW'(cnt_q) + XW'(1);
  assign cnt_ext   = XW'(cnt_q);

  assign ram_re    = issue;
  assign ram_raddr = head_q + rd_idx_q[AW-1:0];

  // write port: head insert, finish write-back or compaction move
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = head_q;
    ram_wdata = ram_rdata;
    if (cmd_i.prep) begin
      ram_we    = (op_q == CMD_WRITE) && (cnt_q != CW'(MaxVersions));
      ram_waddr = head_q - AW'(1);
      ram_wdata = '{done: 1'b0, vref: vref_q, ts: ts_q, txn: txn_q};
    end else if (pend_q) begin
      if (compact_q) begin
        ram_we    = !drop;
        ram_waddr = head_q + wr_idx_q[AW-1:0];
      end else if (op_q == CMD_FINISH) begin
        ram_we         = match_txn;
        ram_waddr      = head_q + pend_idx_q[AW-1:0];
        ram_wdata.done = 1'b1;
      end
    end
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_data_i[1:0];
      txn_q    <= in_data_i[33:2];
      ts_q     <= in_data_i[81:34];
      vref_q   <= in_data_i[113:82];
      min_ts_q <= in_data_i[161:114];
    end
    if (pend_q && !hit_q && (op_q == CMD_READ) && (ram_rdata.done || match_txn)) begin
      hit_ref_q <= ram_rdata.vref;
    end
  end

  // control state of the store and scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= THR_W'(16);
      head_q     <= '0;
      cnt_q      <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      pend_idx_q <= '0;
      pend_q     <= 1'b0;
      hit_q      <= 1'b0;
      full_q     <= 1'b0;
      compact_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      pend_q     <= issue;
      pend_idx_q <= rd_idx_q;
      if (issue) begin
        rd_idx_q <= rd_idx_q + CW'(1);
      end
      if (cmd_i.prep) begin
        hit_q     <= 1'b0;
        full_q    <= 1'b0;
        compact_q <= 1'b0;
        rd_idx_q  <= '0;
        wr_idx_q  <= '0;
        case (op_q)
          CMD_WRITE: begin
            if (cnt_q == CW'(MaxVersions)) begin
              full_q   <= 1'b1;
              rd_idx_q <= cnt_q;
            end else begin
              head_q <= head_q - AW'(1);
              cnt_q  <= cnt_q + CW'(1);
              if (cnt_inc >= XW'(thr_q)) begin
                compact_q <= 1'b1;
                rd_idx_q  <= CW'(1);
                wr_idx_q  <= CW'(1);
              end else begin
                rd_idx_q <= cnt_q + CW'(1);
              end
            end
          end
          CMD_ROLLBACK: compact_q <= 1'b1;
          default: ;
        endcase
      end
      if (pend_q && !hit_q && (op_q == CMD_READ) && (ram_rdata.done || match_txn)) begin
        hit_q <= 1'b1;
      end
      if (pend_q && compact_q && !drop) begin
        wr_idx_q <= wr_idx_q + CW'(1);
      end
      // compaction end: survivors form the new count
      if (cmd_i.scan && scan_done && compact_q) begin
        cnt_q     <= wr_idx_q;
        compact_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_handle_q <= ((op_q == CMD_READ) && hit_q) ? hit_ref_q : '0;
      out_origin_q <= (op_q == CMD_READ) && !hit_q;
      out_status_q <= full_q;
      out_cnt_q    <= cnt_ext[CNTO_W-1:0];
    end
  end

  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = {1'b0, out_cnt_q, out_status_q, out_origin_q, out_handle_q};

  // count never exceeds the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MaxVersions))
    else $error("version count above capacity");

  // a finished command always leaves a result on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.fin |=> out_valid_q)
    else $error("result not presented after finish");

  // a returned entry belongs to a read issued the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> $past(cmd_i.scan))
    else $error("entry returned without a scan read");

endmodule

### rtl/mvcc_version_chain_table_core.sv
// top level of the version chain table
// One command beat is taken at a time and yields one result beat. After
// acceptance a command passes through a prepare step, its scan and a finish
// step that loads the result register. The scan reads the entries through
// the single read port of the entry ram and ends without a read when no
// entry is walked. A read stops at the first visible entry, with at most one
// more entry read behind the hit; finish and rollback walk the whole list,
// and a write with pruning walks every entry behind the new head. A new
// command is taken only once the previous one has finished, and it is taken
// even while the previous result still waits in the output register; that
// command then holds in its finish step until the waiting beat is taken.
module mvcc_version_chain_table_core #(
  parameter int unsigned MAX_VERSIONS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mvcc_pkg::THR_W-1:0]    cfg_wdata_i,   // gc_threshold
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd, txn_id, timestamp, new_version_ref, min_active_ts
  input  logic [mvcc_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // version_handle, from_origin, status, count_after
  output logic [mvcc_pkg::OUT_W-1:0]    m_axis_tdata
);
  import mvcc_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mvcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mvcc_dpath #(
    .MaxVersions (MAX_VERSIONS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
